// ===== rtl/firmata_receive_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Firmata receive parser assertion macros
// Clocked assertion helpers used by the parser top level. Define ASSERT_OFF to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef FIRMATA_RECEIVE_PARSER_ASSERT_SVH
`define FIRMATA_RECEIVE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property sampled on the rising clock edge, disabled during reset.
`define FRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication, disabled during reset.
`define FRP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`else

`define FRP_ASSERT(label, prop, msg)
`define FRP_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

// ===== rtl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// Firmata receive parser package
// Shared types, protocol codes and helper functions of the receive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

   // Default sizes of the value history stores.
   localparam int ANALOG_CHANNELS_DEF = 16;
   localparam int DIGITAL_PORTS_DEF   = 3;
   // Only ports 0 to 2 have a pin layout.
   localparam int PIN_PORTS           = 3;

   // Protocol command bytes.
   localparam logic [7:0] CMD_DIGITAL     = 8'h90;
   localparam logic [7:0] CMD_ANALOG      = 8'hE0;
   localparam logic [7:0] CMD_VERSION     = 8'hF9;
   localparam logic [7:0] CMD_SYSEX_START = 8'hF0;
   localparam logic [7:0] CMD_SYSEX_END   = 8'hF7;

   // Result kinds.
   localparam logic [2:0] KIND_DIGITAL    = 3'd0;
   localparam logic [2:0] KIND_ANALOG     = 3'd1;
   localparam logic [2:0] KIND_VERSION    = 3'd2;
   localparam logic [2:0] KIND_SYSEX_BYTE = 3'd3;
   localparam logic [2:0] KIND_SYSEX_END  = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_DIGITAL_INPUT_MASK = 1'b0;
   localparam logic CSR_NEW_PIN_LAYOUT     = 1'b1;

   // Receive state: idle, first data byte awaited, second awaited, in sysex.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT_FIRST,
      ST_WAIT_SECOND,
      ST_SYSEX
   } frp_state_type;

   // Command whose data bytes are being collected.
   typedef enum logic [1:0] {
      PCMD_DIGITAL,
      PCMD_ANALOG,
      PCMD_VERSION
   } frp_pcmd_type;

   // Completed data sample handed to the change tracker.
   typedef struct packed {
      logic        fire;
      logic        is_digital;
      logic        is_analog;
      logic [3:0]  channel;
      logic [13:0] value;
   } frp_sample_type;

   // Result fields produced by the decoder.
   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  channel;
      logic [13:0] value;
      logic        last;
   } frp_result_type;

   // Pins that physically exist on a port, by pin layout.
   function automatic logic [7:0] port_pin_bits(input logic [1:0] port,
                                                input logic       new_layout);
      logic [7:0] bits;
      case (port)
         2'd0: bits = 8'hFC;
         2'd1: bits = new_layout ? 8'hFF : 8'h3F;
         2'd2: bits = new_layout ? 8'h0F : 8'h3F;
         default: bits = 8'h00;
      endcase
      return bits;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/frp_decode.sv =====
// ----------------------------------------------------------------------------
// Firmata receive parser byte decoder
// Tracks command, data collection and sysex state, and forms the result
// fields of the byte held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [7:0]            rx_byte,
   output frp_pkg::frp_state_type     state,
   output logic                       has_result,
   output frp_pkg::frp_result_type    result,
   output frp_pkg::frp_sample_type    sample
);

   frp_pkg::frp_state_type state_ff, state_in;
   frp_pkg::frp_state_type cmd_state;
   frp_pkg::frp_pcmd_type  pcmd_ff, pcmd_in;
   logic [3:0]             pchan_ff, pchan_in;
   logic [6:0]             first_ff, first_in;

   logic       is_data;
   logic       is_plain;
   logic       complete;
   logic       in_sysex;
   logic       parse_cmd;
   logic [7:0] cmd;

   // Byte classification. Bytes below 0xF0 carry a channel in the low nibble.
   assign is_data  = ~rx_byte[7];
   assign is_plain = (rx_byte[7:4] != 4'hF);
   assign cmd      = is_plain ? {rx_byte[7:4], 4'h0} : rx_byte;
   assign complete = (state_ff == frp_pkg::ST_WAIT_SECOND) && is_data;
   assign in_sysex = (state_ff == frp_pkg::ST_SYSEX);
   assign parse_cmd = ~in_sysex && ~(is_data && ((state_ff == frp_pkg::ST_WAIT_FIRST) ||
                                                (state_ff == frp_pkg::ST_WAIT_SECOND)));

   // State reached when the byte is taken as a command.
   always_comb begin
      if ((cmd == frp_pkg::CMD_DIGITAL) || (cmd == frp_pkg::CMD_ANALOG) ||
          (cmd == frp_pkg::CMD_VERSION)) begin
         cmd_state = frp_pkg::ST_WAIT_FIRST;
      end else if (cmd == frp_pkg::CMD_SYSEX_START) begin
         cmd_state = frp_pkg::ST_SYSEX;
      end else begin
         cmd_state = state_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         case (state_ff)
            frp_pkg::ST_WAIT_FIRST: begin
               state_in = is_data ? frp_pkg::ST_WAIT_SECOND : cmd_state;
            end
            frp_pkg::ST_WAIT_SECOND: begin
               state_in = is_data ? frp_pkg::ST_IDLE : cmd_state;
            end
            frp_pkg::ST_SYSEX: begin
               state_in = (rx_byte == frp_pkg::CMD_SYSEX_END) ? frp_pkg::ST_IDLE
                                                              : frp_pkg::ST_SYSEX;
            end
            default: begin
               state_in = cmd_state;
            end
         endcase
      end
   end

   // Pending command, channel and first data byte.
   always_comb begin
      pcmd_in  = pcmd_ff;
      pchan_in = pchan_ff;
      first_in = first_ff;
      if (advance) begin
         if (parse_cmd) begin
            if (is_plain) begin
               pchan_in = rx_byte[3:0];
            end
            if (cmd == frp_pkg::CMD_DIGITAL) begin
               pcmd_in = frp_pkg::PCMD_DIGITAL;
            end else if (cmd == frp_pkg::CMD_ANALOG) begin
               pcmd_in = frp_pkg::PCMD_ANALOG;
            end else if (cmd == frp_pkg::CMD_VERSION) begin
               pcmd_in = frp_pkg::PCMD_VERSION;
            end
         end
         if ((state_ff == frp_pkg::ST_WAIT_FIRST) && is_data) begin
            first_in = rx_byte[6:0];
         end
      end
   end

   // Result fields of the current byte.
   always_comb begin
      result.kind    = frp_pkg::KIND_SYSEX_BYTE;
      result.channel = 4'd0;
      result.value   = {6'd0, rx_byte};
      result.last    = 1'b0;
      if (complete) begin
         result.value = {rx_byte[6:0], first_ff};
         case (pcmd_ff)
            frp_pkg::PCMD_DIGITAL: begin
               result.kind    = frp_pkg::KIND_DIGITAL;
               result.channel = pchan_ff;
            end
            frp_pkg::PCMD_ANALOG: begin
               result.kind    = frp_pkg::KIND_ANALOG;
               result.channel = pchan_ff;
            end
            default: begin
               result.kind = frp_pkg::KIND_VERSION;
            end
         endcase
      end else if (rx_byte == frp_pkg::CMD_SYSEX_END) begin
         result.kind  = frp_pkg::KIND_SYSEX_END;
         result.value = 14'd0;
         result.last  = 1'b1;
      end
   end

   assign has_result = complete || in_sysex;
   assign state      = state_ff;

   assign sample.fire       = advance && complete;
   assign sample.is_digital = (pcmd_ff == frp_pkg::PCMD_DIGITAL);
   assign sample.is_analog  = (pcmd_ff == frp_pkg::PCMD_ANALOG);
   assign sample.channel    = pchan_ff;
   assign sample.value      = {rx_byte[6:0], first_ff};

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frp_pkg::ST_IDLE;
         pcmd_ff  <= frp_pkg::PCMD_DIGITAL;
         pchan_ff <= 4'd0;
         first_ff <= 7'd0;
      end else begin
         state_ff <= state_in;
         pcmd_ff  <= pcmd_in;
         pchan_ff <= pchan_in;
         first_ff <= first_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/frp_change.sv =====
// ----------------------------------------------------------------------------
// Firmata receive parser change tracker
// Keeps the last analog value per channel and the last pin levels per
// digital port, and forms the change flags of each completed sample.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_change #(
   parameter int ANALOG_CHANNELS = frp_pkg::ANALOG_CHANNELS_DEF,
   parameter int DIGITAL_PORTS   = frp_pkg::DIGITAL_PORTS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire frp_pkg::frp_sample_type sample,
   input  wire logic [23:0]             digital_input_mask,
   input  wire logic                    new_pin_layout,
   output logic [7:0]                   changed
);

   localparam int AW = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
   localparam int DP = (DIGITAL_PORTS < frp_pkg::PIN_PORTS) ? DIGITAL_PORTS
                                                            : frp_pkg::PIN_PORTS;
   localparam int DW = (DP > 1) ? $clog2(DP) : 1;
   localparam logic [4:0] ACH_LIMIT  = 5'(ANALOG_CHANNELS);
   localparam logic [4:0] PORT_LIMIT = 5'(DP);

   logic [13:0]                alast_ff [ANALOG_CHANNELS];
   logic [ANALOG_CHANNELS-1:0] avalid_ff, avalid_in;
   logic [7:0]                 dlast_ff [DP];
   logic [7:0]                 dseen_ff [DP];
   logic [7:0]                 dlast_in, dseen_in;

   logic [AW-1:0] aidx;
   logic [DW-1:0] didx;
   logic          a_hit, d_hit;
   logic          a_wr, d_wr;
   logic          a_changed;
   logic [7:0]    mask_slice;
   logic [7:0]    inputs;
   logic [7:0]    sample_bits;
   logic [7:0]    d_changed;

   // Channels beyond the stores report no change and store nothing.
   assign a_hit = ({1'b0, sample.channel} < ACH_LIMIT);
   assign d_hit = ({1'b0, sample.channel} < PORT_LIMIT);
   assign aidx  = sample.channel[AW-1:0];
   assign didx  = sample.channel[DW-1:0];
   assign a_wr  = sample.fire && sample.is_analog && a_hit;
   assign d_wr  = sample.fire && sample.is_digital && d_hit;

   // Analog: a change only counts against a stored earlier value.
   assign a_changed = a_hit && avalid_ff[aidx] && (alast_ff[aidx] != sample.value);

   // Digital: input pins of the port; a pin never seen counts as changed.
   always_comb begin
      case (sample.channel[1:0])
         2'd0:    mask_slice = digital_input_mask[7:0];
         2'd1:    mask_slice = digital_input_mask[15:8];
         2'd2:    mask_slice = digital_input_mask[23:16];
         default: mask_slice = 8'h00;
      endcase
   end

   assign inputs      = mask_slice & frp_pkg::port_pin_bits(sample.channel[1:0],
                                                            new_pin_layout);
   assign sample_bits = sample.value[7:0];
   assign d_changed   = ((sample_bits ^ dlast_ff[didx]) | ~dseen_ff[didx]) & inputs;
   assign dlast_in    = (dlast_ff[didx] & ~inputs) | (sample_bits & inputs);
   assign dseen_in    = dseen_ff[didx] | inputs;

   always_comb begin
      if (sample.is_digital) begin
         changed = d_hit ? d_changed : 8'h00;
      end else if (sample.is_analog) begin
         changed = {7'd0, a_changed};
      end else begin
         changed = 8'h00;
      end
   end

   // Analog valid bits.
   always_comb begin
      avalid_in = avalid_ff;
      if (a_wr) begin
         avalid_in[aidx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avalid_ff <= '0;
      end else begin
         avalid_ff <= avalid_in;
      end
   end

   // Analog values; an entry is only read once its valid bit is set.
   always_ff @(posedge clock) begin
      if (a_wr) begin
         alast_ff[aidx] <= sample.value;
      end
   end

   // Digital pins seen so far.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DP; i++) begin
            dseen_ff[i] <= 8'h00;
         end
      end else if (d_wr) begin
         dseen_ff[didx] <= dseen_in;
      end
   end

   // Digital pin levels; unseen levels are masked by the seen bits.
   always_ff @(posedge clock) begin
      if (d_wr) begin
         dlast_ff[didx] <= dlast_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/firmata_receive_parser.sv =====
// ----------------------------------------------------------------------------
// Firmata receive parser
// Parses received bytes of a Firmata serial link into digital port, analog,
// protocol version and sysex results.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the req_ channel (req_valid, req_stall, req_rx_byte).
//   A transaction is taken at a clock edge with req_valid high and req_stall
//   low. Results leave on the rsp_ channel under the same rules; a byte
//   gives zero or one result. Configuration is written through csr_write,
//   csr_index and csr_wdata while no transaction is in flight.
//   A taken byte is decoded from the input register and its result is held
//   in the output register until taken. Throughput: one byte per cycle
//   through decode and change logic while no result waits on a stalled receiver.
//   When the receiver stalls, a result waits in the output register; bytes
//   that give no result keep flowing, and a byte that needs the full output
//   register waits in the input register, which raises req_stall.
//   Reset is synchronous and clears the parse state, the change history and
//   both configuration registers; the block is ready in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "firmata_receive_parser_assert.svh"

module firmata_receive_parser #(
   parameter int ANALOG_CHANNELS = frp_pkg::ANALOG_CHANNELS_DEF,
   parameter int DIGITAL_PORTS   = frp_pkg::DIGITAL_PORTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [3:0]       rsp_channel,
   output logic [13:0]      rsp_value,
   output logic [7:0]       rsp_changed,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [3:0]  channel_ff, channel_in;
   logic [13:0] value_ff, value_in;
   logic [7:0]  changed_ff, changed_in;
   logic        last_ff, last_in;
   logic [23:0] mask_ff, mask_in;
   logic        layout_ff, layout_in;

   logic                    process;
   logic                    req_take;
   logic                    has_result;
   logic [7:0]              changed;
   frp_pkg::frp_state_type  state;
   frp_pkg::frp_result_type result;
   frp_pkg::frp_sample_type sample;

   // Configuration registers.
   always_comb begin
      mask_in   = mask_ff;
      layout_in = layout_ff;
      if (csr_write) begin
         case (csr_index)
            frp_pkg::CSR_DIGITAL_INPUT_MASK: mask_in   = csr_wdata;
            frp_pkg::CSR_NEW_PIN_LAYOUT:     layout_in = csr_wdata[0];
            default: begin
               mask_in   = mask_ff;
               layout_in = layout_ff;
            end
         endcase
      end
   end

   // A held byte is processed unless its result finds the output register full.
   assign process   = in_valid_ff && (~has_result || ~out_valid_ff || ~rsp_stall);
   assign req_stall = in_valid_ff && ~process;
   assign req_take  = req_valid && ~req_stall;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   frp_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (process),
      .rx_byte    (in_byte_ff),
      .state      (state),
      .has_result (has_result),
      .result     (result),
      .sample     (sample)
   );

   frp_change #(
      .ANALOG_CHANNELS (ANALOG_CHANNELS),
      .DIGITAL_PORTS   (DIGITAL_PORTS)
   ) u_change (
      .clock              (clock),
      .reset              (reset),
      .sample             (sample),
      .digital_input_mask (mask_ff),
      .new_pin_layout     (layout_ff),
      .changed            (changed)
   );

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      channel_in   = channel_ff;
      value_in     = value_ff;
      changed_in   = changed_ff;
      last_in      = last_ff;
      if (process && has_result) begin
         out_valid_in = 1'b1;
         kind_in      = result.kind;
         channel_in   = result.channel;
         value_in     = result.value;
         changed_in   = (state == frp_pkg::ST_SYSEX) ? 8'h00 : changed;
         last_in      = result.last;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mask_ff      <= 24'd0;
         layout_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mask_ff      <= mask_in;
         layout_ff    <= layout_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      kind_ff    <= kind_in;
      channel_ff <= channel_in;
      value_ff   <= value_in;
      changed_ff <= changed_in;
      last_ff    <= last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_channel = channel_ff;
   assign rsp_value   = value_ff;
   assign rsp_changed = changed_ff;
   assign rsp_last    = last_ff;

   // A byte held back by a full output register stays in the input register.
   `FRP_ASSERT(a_held_byte_kept, req_stall |=> (in_valid_ff && $stable(in_byte_ff)),
               "held input byte was lost or changed")
   // The end flag only comes with the sysex end result.
   `FRP_ASSERT_IMPLY(a_last_only_on_end, rsp_valid && rsp_last,
                     rsp_kind == frp_pkg::KIND_SYSEX_END, "last set on a non-end result")
   // Analog results flag a change in bit 0 only.
   `FRP_ASSERT_IMPLY(a_analog_flag_bit0, rsp_valid && (rsp_kind == frp_pkg::KIND_ANALOG),
                     rsp_changed[7:1] == 7'd0, "analog change flag outside bit 0")
   // A sysex result is only formed while the decoder is inside sysex.
   `FRP_ASSERT_IMPLY(a_sysex_from_state, process && has_result &&
                     ((result.kind == frp_pkg::KIND_SYSEX_BYTE) ||
                      (result.kind == frp_pkg::KIND_SYSEX_END)),
                     state == frp_pkg::ST_SYSEX, "sysex result outside sysex")

endmodule

`default_nettype wire
